@@ hdl/jtc_pkg.sv @@
// Package for the joystick teleop conditioner: types, register indexes, constants.
// No dependencies.
package jtc_pkg;

  localparam int ONE_Q14 = 16384;
  localparam int STOP_EPS = 16;

  typedef enum logic [2:0] {
    REG_STICK_DB    = 3'd0,
    REG_TWIST_DB    = 3'd1,
    REG_HAT_DB      = 3'd2,
    REG_THROTTLE_DB = 3'd3,
    REG_RAMP_STEP   = 3'd4,
    REG_CART_TO     = 3'd5,
    REG_JSTOP_AFTER = 3'd6,
    REG_JSTOP_BEFOR = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_TWIST   = 2'd0,
    KIND_JOG     = 2'd1,
    KIND_GRIPPER = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_DB_SETUP,
    ST_DB_DIV,
    ST_RAMP,
    ST_TICK,
    ST_TICK_RAMP,
    ST_TICK_JOINT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] vel_a;
    logic signed [15:0] vel_b;
    logic signed [15:0] vel_c;
    logic signed [15:0] vel_d;
    logic signed [15:0] vel_e;
    logic signed [15:0] vel_f;
    logic               frame_is_base;
    logic               gripper_open;
    logic               last_result;
  } result_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] axis_stick_x;
    logic signed [15:0] axis_stick_y;
    logic signed [15:0] axis_stick_twist;
    logic signed [15:0] axis_throttle;
    logic signed [15:0] axis_hat_x;
    logic signed [15:0] axis_hat_y;
    logic [11:0]        button_mask;
    logic [3:0]         button_count;
    logic [31:0]        time_ms;
  } item_t;

  function automatic logic signed [15:0] sat_q14(input logic signed [15:0] v);
    if (v > 16'sd16384) return 16'sd16384;
    if (v < -16'sd16384) return -16'sd16384;
    return v;
  endfunction

endpackage

@@ hdl/jtc_if.sv @@
// Valid/ready channel interfaces for items, results and register writes.
// Depends on jtc_pkg.
interface jtc_item_if import jtc_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jtc_result_if import jtc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jtc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/joystick_teleop_conditioner.sv @@
// A sample runs six deadband divisions on one shared restoring divider,
// 29 quotient bits at one per cycle; an axis inside the deadband skips its division.
// in_ready stays low until all results (up to two) of the item have been taken.
// Reset (rst_n low, synchronous): registers to defaults, velocities zero, frame base.
module joystick_teleop_conditioner import jtc_pkg::*; (
  input logic clk,
  input logic rst_n,
  jtc_item_if.sink     in_ch,
  jtc_result_if.source out_ch,
  jtc_cfg_if.sink      cfg_ch
);

  logic [13:0] stick_db_r, twist_db_r, hat_db_r, thr_db_r;
  logic [14:0] ramp_step_r;
  logic [15:0] cart_to_r, jafter_r, jbefore_r;

  state_t state_r, state_nxt;
  item_t  item_r;
  logic signed [15:0] vel_r [6];
  logic signed [15:0] tgt_r [6];
  logic        base_frame_r, grip_open_r, trig_prev_r, grip_prev_r, started_r;
  logic [31:0] last_cart_r, last_joint_r;
  logic [2:0]  ax_r;
  result_t     pend_r [2];
  logic [1:0]  pend_cnt_r;
  logic        out_valid_r;
  result_t     out_data_r;

  // divider
  logic [28:0] rem_r;
  logic [28:0] dvd_r;
  logic [14:0] dvs_r;
  logic [14:0] quo_r;
  logic [4:0]  bit_r;
  logic        neg_r, zero_r;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:       if (in_ch.valid) state_nxt = in_ch.data.command ? ST_TICK : ST_SAMPLE;
      ST_SAMPLE:     state_nxt = ST_DB_SETUP;
      ST_DB_SETUP:   state_nxt = ST_DB_DIV;
      ST_DB_DIV:     if (zero_r || bit_r == 5'd0)
                       state_nxt = (ax_r == 3'd5) ? ST_RAMP : ST_DB_SETUP;
      ST_RAMP:       state_nxt = ST_EMIT;
      ST_TICK:       state_nxt = ST_TICK_RAMP;
      ST_TICK_RAMP:  state_nxt = ST_TICK_JOINT;
      ST_TICK_JOINT: state_nxt = ST_EMIT;
      ST_EMIT:       if (pend_cnt_r == 2'd0 && !out_valid_r)
                       state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // axis source for current deadband
  logic signed [15:0] ax_in;
  logic [13:0]        ax_db;
  logic signed [15:0] thr;
  always_comb begin
    thr = sat_q14(item_r.axis_throttle) / 16'sd2;
    case (ax_r)
      3'd0:    begin ax_in = sat_q14(item_r.axis_stick_y); ax_db = stick_db_r; end
      3'd1:    begin ax_in = sat_q14(item_r.axis_stick_x); ax_db = stick_db_r; end
      3'd2:    begin ax_in = thr; ax_db = thr_db_r; end
      3'd3:    begin ax_in = sat_q14(item_r.axis_hat_y); ax_db = hat_db_r; end
      3'd4:    begin ax_in = sat_q14(item_r.axis_hat_x); ax_db = hat_db_r; end
      default: begin ax_in = sat_q14(item_r.axis_stick_twist); ax_db = twist_db_r; end
    endcase
  end

  logic [15:0] ax_mag;
  assign ax_mag = ax_in[15] ? 16'(-ax_in) : 16'(ax_in);

  // ramp helper
  function automatic logic signed [15:0] ramp_f(input logic signed [15:0] cur,
      input logic signed [15:0] tgt, input logic [14:0] step);
    logic signed [17:0] e;
    logic [17:0] ae;
    e = 18'(tgt) - 18'(cur);
    ae = e[17] ? 18'(-e) : 18'(e);
    if (ae <= {3'd0, step}) return tgt;
    if (!e[17]) return 16'(18'(cur) + {3'd0, step});
    return 16'(18'(cur) - {3'd0, step});
  endfunction

  logic [11:0] btn;
  always_comb begin
    btn = item_r.button_mask;
    for (int i = 0; i < 12; i++) if (i >= int'(item_r.button_count)) btn[i] = 1'b0;
  end
  logic jog_req;
  assign jog_req = (item_r.button_count >= 4'd12) && (btn[10:2] != 9'd0);

  logic signed [15:0] rv [6];
  logic               moving;
  always_comb begin
    moving = 1'b0;
    for (int i = 0; i < 6; i++) begin
      rv[i] = ramp_f(vel_r[i], 16'sd0, ramp_step_r);
      if (rv[i] > 16'sd16 || rv[i] < -16'sd16) moving = 1'b1;
    end
  end

  logic [31:0] dc, dj;
  assign dc = item_r.time_ms - last_cart_r;
  assign dj = item_r.time_ms - last_joint_r;

  function automatic logic signed [15:0] jv(input logic p, input logic q);
    if (p && !q) return 16'sd16384;
    if (q && !p) return -16'sd16384;
    return 16'sd0;
  endfunction

  function automatic result_t mk(input logic [1:0] k, input logic signed [15:0] a,
      input logic signed [15:0] b, input logic signed [15:0] c,
      input logic signed [15:0] d, input logic signed [15:0] e,
      input logic signed [15:0] f, input logic fr, input logic gr);
    result_t r;
    r.kind = k; r.vel_a = a; r.vel_b = b; r.vel_c = c; r.vel_d = d;
    r.vel_e = e; r.vel_f = f; r.frame_is_base = fr; r.gripper_open = gr;
    r.last_result = 1'b0;
    return r;
  endfunction

  logic [29:0] trial;
  assign trial = {rem_r[27:0], dvd_r[28]} - {15'd0, dvs_r};
  logic signed [15:0] q_s;
  assign q_s = neg_r ? -16'(quo_r) : 16'(quo_r);

  logic grip_edge;
  assign grip_edge = btn[1] && !grip_prev_r;

  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && (pend_cnt_r != 2'd0) &&
                   (!out_valid_r || out_ch.ready);

  result_t emit_d;
  always_comb begin
    emit_d = pend_r[0];
    emit_d.last_result = (pend_cnt_r == 2'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_db_r <= 14'd2458; twist_db_r <= 14'd3277; hat_db_r <= 14'd819;
      thr_db_r <= 14'd819; ramp_step_r <= 15'd655; cart_to_r <= 16'd200;
      jafter_r <= 16'd200; jbefore_r <= 16'd300;
      state_r <= ST_IDLE;
      for (int i = 0; i < 6; i++) vel_r[i] <= 16'sd0;
      base_frame_r <= 1'b1; grip_open_r <= 1'b0; trig_prev_r <= 1'b0;
      grip_prev_r <= 1'b0; started_r <= 1'b0;
      last_cart_r <= 32'd0; last_joint_r <= 32'd0;
      pend_cnt_r <= 2'd0; out_valid_r <= 1'b0;
      ax_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (reg_idx_t'(cfg_ch.index))
          REG_STICK_DB:    stick_db_r <= cfg_ch.wdata[13:0];
          REG_TWIST_DB:    twist_db_r <= cfg_ch.wdata[13:0];
          REG_HAT_DB:      hat_db_r <= cfg_ch.wdata[13:0];
          REG_THROTTLE_DB: thr_db_r <= cfg_ch.wdata[13:0];
          REG_RAMP_STEP:   ramp_step_r <= cfg_ch.wdata[14:0];
          REG_CART_TO:     cart_to_r <= cfg_ch.wdata;
          REG_JSTOP_AFTER: jafter_r <= cfg_ch.wdata;
          REG_JSTOP_BEFOR: jbefore_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_ch.valid) begin
          item_r <= in_ch.data;
          pend_cnt_r <= 2'd0; ax_r <= 3'd0;
        end
        ST_SAMPLE: begin
          if (!started_r) started_r <= 1'b1;
          if (!jog_req || !started_r) last_cart_r <= item_r.time_ms;
          if (jog_req || !started_r) last_joint_r <= item_r.time_ms;
          if (btn[0] && !trig_prev_r) base_frame_r <= ~base_frame_r;
          trig_prev_r <= btn[0];
          grip_prev_r <= btn[1];
          if (grip_edge) begin
            grip_open_r <= ~grip_open_r;
            pend_r[0] <= mk(KIND_GRIPPER, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
              1'b0, ~grip_open_r);
          end
          if (jog_req) begin
            for (int i = 0; i < 6; i++) vel_r[i] <= 16'sd0;
            if (grip_edge) begin
              pend_r[1] <= mk(KIND_JOG, jv(btn[2], btn[3]), jv(btn[4], btn[5]),
                jv(btn[6], btn[7]), jv(btn[8], btn[9]), jv(btn[10], 1'b0), 16'sd0,
                1'b1, 1'b0);
              pend_cnt_r <= 2'd2;
            end else begin
              pend_r[0] <= mk(KIND_JOG, jv(btn[2], btn[3]), jv(btn[4], btn[5]),
                jv(btn[6], btn[7]), jv(btn[8], btn[9]), jv(btn[10], 1'b0), 16'sd0,
                1'b1, 1'b0);
              pend_cnt_r <= 2'd1;
            end
          end else begin
            pend_cnt_r <= grip_edge ? 2'd1 : 2'd0;
          end
        end
        ST_DB_SETUP: begin
          neg_r <= ax_in[15];
          zero_r <= ax_mag < {2'd0, ax_db};
          dvd_r <= {15'(ax_mag - {2'd0, ax_db}), 14'd0};
          dvs_r <= 15'(15'd16384 - {1'b0, ax_db});
          rem_r <= 29'd0; quo_r <= 15'd0; bit_r <= 5'd29;
        end
        ST_DB_DIV: begin
          if (zero_r || bit_r == 5'd0) begin
            tgt_r[ax_r] <= zero_r ? 16'sd0 :
              ((ax_r == 3'd1 || ax_r == 3'd4) ? -q_s : q_s);
            ax_r <= ax_r + 3'd1;
          end else begin
            bit_r <= bit_r - 5'd1;
            dvd_r <= {dvd_r[27:0], 1'b0};
            if (!trial[29]) begin
              rem_r <= trial[28:0]; quo_r <= {quo_r[13:0], 1'b1};
            end else begin
              rem_r <= {rem_r[27:0], dvd_r[28]}; quo_r <= {quo_r[13:0], 1'b0};
            end
          end
        end
        ST_RAMP: begin
          if (!jog_req) begin
            for (int i = 0; i < 6; i++) vel_r[i] <= ramp_f(vel_r[i], tgt_r[i], ramp_step_r);
            pend_r[pend_cnt_r[0]] <= mk(KIND_TWIST,
              ramp_f(vel_r[0], tgt_r[0], ramp_step_r), ramp_f(vel_r[1], tgt_r[1], ramp_step_r),
              ramp_f(vel_r[2], tgt_r[2], ramp_step_r), ramp_f(vel_r[3], tgt_r[3], ramp_step_r),
              ramp_f(vel_r[4], tgt_r[4], ramp_step_r), ramp_f(vel_r[5], tgt_r[5], ramp_step_r),
              base_frame_r, 1'b0);
            pend_cnt_r <= pend_cnt_r + 2'd1;
          end
        end
        ST_TICK: ;
        ST_TICK_RAMP: if (started_r && dc > {16'd0, cart_to_r}) begin
          for (int i = 0; i < 6; i++) vel_r[i] <= rv[i];
          if (moving) begin
            pend_r[0] <= mk(KIND_TWIST, rv[0], rv[1], rv[2], rv[3], rv[4], rv[5],
              base_frame_r, 1'b0);
            pend_cnt_r <= 2'd1;
          end
        end
        ST_TICK_JOINT: if (started_r && dj > {16'd0, jafter_r} && dj < {16'd0, jbefore_r}) begin
          pend_r[pend_cnt_r[0]] <= mk(KIND_JOG, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
            16'sd0, 1'b1, 1'b0);
          pend_cnt_r <= pend_cnt_r + 2'd1;
        end
        ST_EMIT: if (emit_go) begin
          out_data_r <= emit_d;
          pend_r[0] <= pend_r[1];
          pend_cnt_r <= pend_cnt_r - 2'd1;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ bench/tb_joystick_teleop_conditioner.sv @@
// Testbench for joystick_teleop_conditioner: random and directed samples and ticks,
// checked against an in-bench behavioral predictor through a scoreboard class.
// Depends on jtc_pkg, jtc_if and the RTL top level.
`timescale 1ns / 100ps

module tb_joystick_teleop_conditioner;
  import jtc_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  jtc_item_if   in_ch ();
  jtc_result_if out_ch ();
  jtc_cfg_if    cfg_ch ();

  joystick_teleop_conditioner u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  class teleop_scoreboard;
    int unsigned regs[8];
    int vel[6];
    bit base_frame, grip_open, trig_prev, grip_prev, started;
    logic [31:0] last_cart, last_joint;
    result_t pending[$];
    int errors;

    function void reset_state();
      regs = '{2458, 3277, 819, 819, 655, 200, 200, 300};
      foreach (vel[i]) vel[i] = 0;
      base_frame = 1; grip_open = 0; trig_prev = 0; grip_prev = 0; started = 0;
      last_cart = 0; last_joint = 0; errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      int unsigned m;
      m = (idx == REG_RAMP_STEP) ? 32'h7FFF : (idx >= REG_CART_TO) ? 32'hFFFF : 32'h3FFF;
      regs[idx] = val & m;
    endfunction

    function int clamp_axis(logic signed [15:0] v);
      int s;
      s = v;
      if (s > ONE_Q14) s = ONE_Q14;
      if (s < -ONE_Q14) s = -ONE_Q14;
      return s;
    endfunction

    function int deadband(int v, int unsigned d);
      int unsigned m, q;
      m = (v < 0) ? -v : v;
      if (m < d) return 0;
      q = ((m - d) * ONE_Q14) / (ONE_Q14 - d);
      return (v < 0) ? -int'(q) : int'(q);
    endfunction

    function int slew(int cur, int tgt, int unsigned stp);
      int e;
      int unsigned ae;
      e = tgt - cur;
      ae = (e < 0) ? -e : e;
      if (ae <= stp) return tgt;
      return (e > 0) ? cur + int'(stp) : cur - int'(stp);
    endfunction

    function void push(kind_t k, int v[6], bit frame, bit grip);
      result_t r;
      r = '0;
      r.kind = k;
      r.vel_a = 16'(v[0]); r.vel_b = 16'(v[1]); r.vel_c = 16'(v[2]);
      r.vel_d = 16'(v[3]); r.vel_e = 16'(v[4]); r.vel_f = 16'(v[5]);
      r.frame_is_base = frame;
      r.gripper_open = grip;
      pending = {pending, r};
    endfunction

    function void note_item(item_t it);
      int zeros[6];
      int t[6];
      int n0;
      logic [11:0] btn;
      logic [31:0] dc, dj;
      bit moving;
      foreach (zeros[i]) zeros[i] = 0;
      n0 = pending.size();
      if (it.command == 1'b0) begin
        btn = it.button_mask;
        if (it.button_count < 12) btn &= (12'd1 << it.button_count) - 12'd1;
        if (!started) begin
          last_cart = it.time_ms; last_joint = it.time_ms; started = 1;
        end
        if (btn[0] && !trig_prev) base_frame ^= 1'b1;
        trig_prev = btn[0];
        if (btn[1] && !grip_prev) begin
          grip_open ^= 1'b1;
          push(KIND_GRIPPER, zeros, 1'b0, grip_open);
        end
        grip_prev = btn[1];
        if (it.button_count >= 12 && (btn & 12'h7FC) != 0) begin
          for (int i = 0; i < 4; i++)
            t[i] = (int'(btn[2 + 2 * i]) - int'(btn[3 + 2 * i])) * ONE_Q14;
          t[4] = int'(btn[10]) * ONE_Q14;
          t[5] = 0;
          foreach (vel[i]) vel[i] = 0;
          push(KIND_JOG, t, 1'b1, 1'b0);
          last_joint = it.time_ms;
        end else begin
          t[0] = deadband(clamp_axis(it.axis_stick_y), regs[REG_STICK_DB]);
          t[1] = -deadband(clamp_axis(it.axis_stick_x), regs[REG_STICK_DB]);
          t[2] = deadband(clamp_axis(it.axis_throttle) / 2, regs[REG_THROTTLE_DB]);
          t[3] = deadband(clamp_axis(it.axis_hat_y), regs[REG_HAT_DB]);
          t[4] = -deadband(clamp_axis(it.axis_hat_x), regs[REG_HAT_DB]);
          t[5] = deadband(clamp_axis(it.axis_stick_twist), regs[REG_TWIST_DB]);
          last_cart = it.time_ms;
          foreach (vel[i]) vel[i] = slew(vel[i], t[i], regs[REG_RAMP_STEP]);
          push(KIND_TWIST, vel, base_frame, 1'b0);
        end
      end else if (started) begin
        dc = it.time_ms - last_cart;
        if (dc > regs[REG_CART_TO]) begin
          moving = 0;
          foreach (vel[i]) begin
            vel[i] = slew(vel[i], 0, regs[REG_RAMP_STEP]);
            if (vel[i] > STOP_EPS || vel[i] < -STOP_EPS) moving = 1;
          end
          if (moving) push(KIND_TWIST, vel, base_frame, 1'b0);
        end
        dj = it.time_ms - last_joint;
        if (dj > regs[REG_JSTOP_AFTER] && dj < regs[REG_JSTOP_BEFOR])
          push(KIND_JOG, zeros, 1'b1, 1'b0);
      end
      if (pending.size() > n0) pending[pending.size() - 1].last_result = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $error("unexpected result kind=%0d", got.kind);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.kind != w.kind) begin $error("kind exp %0d got %0d", w.kind, got.kind); errors++; end
      if (got.vel_a != w.vel_a) begin $error("vel_a exp %0d got %0d", w.vel_a, got.vel_a); errors++; end
      if (got.vel_b != w.vel_b) begin $error("vel_b exp %0d got %0d", w.vel_b, got.vel_b); errors++; end
      if (got.vel_c != w.vel_c) begin $error("vel_c exp %0d got %0d", w.vel_c, got.vel_c); errors++; end
      if (got.vel_d != w.vel_d) begin $error("vel_d exp %0d got %0d", w.vel_d, got.vel_d); errors++; end
      if (got.vel_e != w.vel_e) begin $error("vel_e exp %0d got %0d", w.vel_e, got.vel_e); errors++; end
      if (got.vel_f != w.vel_f) begin $error("vel_f exp %0d got %0d", w.vel_f, got.vel_f); errors++; end
      if (got.frame_is_base != w.frame_is_base) begin
        $error("frame_is_base exp %0d got %0d", w.frame_is_base, got.frame_is_base); errors++;
      end
      if (got.gripper_open != w.gripper_open) begin
        $error("gripper_open exp %0d got %0d", w.gripper_open, got.gripper_open); errors++;
      end
      if (got.last_result != w.last_result) begin
        $error("last_result exp %0d got %0d", w.last_result, got.last_result); errors++;
      end
    endfunction
  endclass

  teleop_scoreboard sb;
  int unsigned cycle_count = 0;
  bit calm_mode = 0;
  bit hold_off = 0;
  logic [31:0] now_ms = 0;

  initial begin
    in_ch.valid = 0; in_ch.data = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.index = REG_STICK_DB; cfg_ch.wdata = '0;
    sb = new();
    sb.reset_state();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 29);
  end

  task automatic write_cfg(reg_idx_t idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(item_t it);
    if (!calm_mode)
      while ($urandom_range(99) < 29) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'($signed($urandom_range(4000)) - 2000);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic item_t make_sample(logic [11:0] mask, logic [3:0] cnt);
    item_t it;
    it.command = 1'b0;
    it.axis_stick_x = rand_axis(); it.axis_stick_y = rand_axis();
    it.axis_stick_twist = rand_axis(); it.axis_throttle = rand_axis();
    it.axis_hat_x = rand_axis(); it.axis_hat_y = rand_axis();
    it.button_mask = mask;
    it.button_count = cnt;
    now_ms = now_ms + $urandom_range(60);
    it.time_ms = now_ms;
    return it;
  endfunction

  function automatic item_t make_tick();
    item_t it;
    it = make_sample(12'($urandom), 4'($urandom));
    it.command = 1'b1;
    now_ms = now_ms + $urandom_range(150);
    it.time_ms = now_ms;
    return it;
  endfunction

  function automatic item_t random_item();
    logic [11:0] m;
    m = 12'($urandom);
    case ($urandom_range(9))
      0, 1, 2: return make_tick();
      3: return make_sample(m, 4'($urandom));
      4: return make_sample(m & 12'h003, 4'd12);
      5: return make_sample(12'h001 << $urandom_range(11), 4'($urandom_range(15)));
      default: return make_sample(m & 12'h803, $urandom_range(1) ? 4'd12 : 4'($urandom));
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_item(random_item());
    end
  endtask

  initial begin
    item_t it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tick before any sample: no result
    it = make_tick();
    send_item(it);
    // directed extremes
    it = make_sample(12'h000, 4'd12);
    it.axis_stick_x = 16'sh7FFF; it.axis_stick_y = 16'sh8000;
    it.axis_stick_twist = 16'sd16384; it.axis_throttle = -16'sd16384;
    it.axis_hat_x = -16'sd16384; it.axis_hat_y = 16'sd0;
    send_item(it);
    send_item(make_sample(12'h001, 4'd12));
    send_item(make_sample(12'h002, 4'd12));
    send_item(make_sample(12'h7FC, 4'd12));
    send_item(make_sample(12'hFFF, 4'd15));
    send_item(make_sample(12'h000, 4'd12));
    send_item(make_sample(12'h556, 4'd12));
    send_item(make_sample(12'hAAA, 4'd12));
    send_item(make_sample(12'hFFF, 4'd11));
    send_item(make_sample(12'hFFF, 4'd0));
    send_item(make_sample(12'h400, 4'd12));
    it = make_tick(); it.time_ms = now_ms + 250; now_ms = it.time_ms;
    send_item(it);
    it = make_tick(); it.time_ms = now_ms + 100000; now_ms = it.time_ms;
    send_item(it);
    it = make_tick(); it.time_ms = now_ms - 32'd5;
    send_item(it);
    drain();

    // extreme register settings
    write_cfg(REG_STICK_DB, 16'h3FFF);
    write_cfg(REG_TWIST_DB, 16'h0000);
    write_cfg(REG_HAT_DB, 16'hFFFF);
    write_cfg(REG_THROTTLE_DB, 16'h0000);
    write_cfg(REG_RAMP_STEP, 16'd16384);
    write_cfg(REG_CART_TO, 16'd0);
    write_cfg(REG_JSTOP_AFTER, 16'd0);
    write_cfg(REG_JSTOP_BEFOR, 16'hFFFF);
    random_phase(200);
    drain();

    write_cfg(REG_RAMP_STEP, 16'd1);
    write_cfg(REG_STICK_DB, 16'd0);
    write_cfg(REG_HAT_DB, 16'd0);
    write_cfg(REG_CART_TO, 16'hFFFF);
    write_cfg(REG_JSTOP_AFTER, 16'd300);
    write_cfg(REG_JSTOP_BEFOR, 16'd100);
    random_phase(150);
    drain();

    // long stall on the result side while items keep coming
    calm_mode = 1;
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_phase(150);
    join
    drain();
    calm_mode = 0;

    for (int p = 0; p < 2; p++) begin
      write_cfg(REG_STICK_DB, 16'($urandom_range(16383)));
      write_cfg(REG_TWIST_DB, 16'($urandom_range(16383)));
      write_cfg(REG_HAT_DB, 16'($urandom_range(16383)));
      write_cfg(REG_THROTTLE_DB, 16'($urandom_range(16383)));
      write_cfg(REG_RAMP_STEP, 16'($urandom_range(16384, 1)));
      write_cfg(REG_CART_TO, 16'($urandom_range(150)));
      write_cfg(REG_JSTOP_AFTER, 16'($urandom_range(100)));
      write_cfg(REG_JSTOP_BEFOR, 16'($urandom_range(400, 100)));
      random_phase(200);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/jtc_pkg.sv
hdl/jtc_if.sv
hdl/joystick_teleop_conditioner.sv
bench/tb_joystick_teleop_conditioner.sv
